FILE: rtl/core/three_channel_square_tone_mixer_core_assert.svh
// assertion macros for the tone mixer core
`ifndef THREE_CHANNEL_SQUARE_TONE_MIXER_CORE_ASSERT_SVH
`define THREE_CHANNEL_SQUARE_TONE_MIXER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TCSM_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TCSM_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCSM_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define TCSM_ASSERT_ALWAYS(lbl, clk_i, prop, msg)
`endif

`endif

FILE: rtl/core/tcsm_pkg.sv
package tcsm_pkg;

	localparam int NOTE_COUNT = 73;
	localparam int TABLE_SIZE = 73;
	// notes below this limit are playable
	localparam logic [7:0] NOTE_LIMIT =
		8'((NOTE_COUNT < TABLE_SIZE) ? NOTE_COUNT : TABLE_SIZE);

	localparam int PERIOD_W = 16;
	localparam int NUM_CH = 3;

	localparam logic [2:0] VOLUME_OFF = 3'd4;
	localparam logic [2:0] VOLUME_RST = 3'd4;
	localparam logic [1:0] WEIGHT_RST = 2'd1;
	localparam logic [1:0] WEIGHT_MAX = 2'd2;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_NOTE = 1'b1;

	typedef enum logic [1:0] {
		CFG_GLOBAL_VOLUME   = 2'd0,
		CFG_CHANNEL2_WEIGHT = 2'd1,
		CFG_OUTPUT_ENABLE   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic                tick;
		logic                start;
		logic                stop;
		logic                clear;
		logic [PERIOD_W-1:0] period;
	} chan_ctrl_t;

	function automatic logic [PERIOD_W-1:0] half_period(input logic [6:0] note);
		logic [PERIOD_W-1:0] p;
		unique case (note)
			7'd0:  p = 16'd38222; 7'd1:  p = 16'd36076; 7'd2:  p = 16'd34051;
			7'd3:  p = 16'd32140; 7'd4:  p = 16'd30336; 7'd5:  p = 16'd28634;
			7'd6:  p = 16'd27026; 7'd7:  p = 16'd25510; 7'd8:  p = 16'd24078;
			7'd9:  p = 16'd22726; 7'd10: p = 16'd21451; 7'd11: p = 16'd20247;
			7'd12: p = 16'd19110; 7'd13: p = 16'd18038; 7'd14: p = 16'd17025;
			7'd15: p = 16'd16070; 7'd16: p = 16'd15168; 7'd17: p = 16'd14316;
			7'd18: p = 16'd13513; 7'd19: p = 16'd12754; 7'd20: p = 16'd12038;
			7'd21: p = 16'd11363; 7'd22: p = 16'd10725; 7'd23: p = 16'd10123;
			7'd24: p = 16'd9555;  7'd25: p = 16'd9018;  7'd26: p = 16'd8512;
			7'd27: p = 16'd8034;  7'd28: p = 16'd7583;  7'd29: p = 16'd7158;
			7'd30: p = 16'd6756;  7'd31: p = 16'd6377;  7'd32: p = 16'd6019;
			7'd33: p = 16'd5681;  7'd34: p = 16'd5362;  7'd35: p = 16'd5061;
			7'd36: p = 16'd4777;  7'd37: p = 16'd4509;  7'd38: p = 16'd4256;
			7'd39: p = 16'd4017;  7'd40: p = 16'd3791;  7'd41: p = 16'd3578;
			7'd42: p = 16'd3377;  7'd43: p = 16'd3188;  7'd44: p = 16'd3009;
			7'd45: p = 16'd2840;  7'd46: p = 16'd2680;  7'd47: p = 16'd2530;
			7'd48: p = 16'd2388;  7'd49: p = 16'd2254;  7'd50: p = 16'd2127;
			7'd51: p = 16'd2008;  7'd52: p = 16'd1895;  7'd53: p = 16'd1789;
			7'd54: p = 16'd1688;  7'd55: p = 16'd1593;  7'd56: p = 16'd1504;
			7'd57: p = 16'd1419;  7'd58: p = 16'd1340;  7'd59: p = 16'd1264;
			7'd60: p = 16'd1193;  7'd61: p = 16'd1126;  7'd62: p = 16'd1063;
			7'd63: p = 16'd1003;  7'd64: p = 16'd947;   7'd65: p = 16'd894;
			7'd66: p = 16'd844;   7'd67: p = 16'd796;   7'd68: p = 16'd751;
			7'd69: p = 16'd709;   7'd70: p = 16'd669;   7'd71: p = 16'd632;
			7'd72: p = 16'd596;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/core/tcsm_channel.sv
module tcsm_channel (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcsm_pkg::chan_ctrl_t  ctrl,
	output logic                  wave_next,
	output logic                  wave_q
);
	import tcsm_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	logic                running_q;
	logic                hit;

	assign hit = (count_q == period_q);

	always_comb begin
		if (ctrl.clear) begin
			wave_next = 1'b0;
		end else if (ctrl.tick && running_q && hit) begin
			wave_next = ~wave_q;
		end else begin
			wave_next = wave_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			count_q   <= '0;
			running_q <= 1'b0;
			wave_q    <= 1'b0;
		end else begin
			wave_q <= wave_next;
			if (ctrl.start) begin
				period_q  <= ctrl.period;
				count_q   <= '0;
				running_q <= 1'b1;
			end else if (ctrl.stop) begin
				running_q <= 1'b0;
			end else if (ctrl.tick && running_q) begin
				count_q <= hit ? '0 : count_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/tcsm_mixer.sv
module tcsm_mixer (
	input  logic [2:0] wave_bits,
	input  logic [2:0] volume,
	input  logic [1:0] weight,
	input  logic       enable,
	output logic [5:0] duty
);
	import tcsm_pkg::*;

	logic [1:0] w2;
	logic [2:0] level;

	// weight 3 behaves as the maximum weight
	assign w2 = (weight > WEIGHT_MAX) ? WEIGHT_MAX : weight;

	assign level = 3'(wave_bits[0]) + 3'(wave_bits[1])
		+ (wave_bits[2] ? 3'(w2) : 3'd0);

	always_comb begin
		if (!enable || volume >= VOLUME_OFF) begin
			duty = '0;
		end else begin
			duty = 6'(6'(level) << volume[1:0]);
		end
	end

endmodule

FILE: rtl/core/three_channel_square_tone_mixer_core.sv
// three square-wave tone channels mixed into one pwm duty value
//
// input stream (s_axis): tuser carries the item kind (tick or note command),
// tdata carries channel, note and note_on. every transaction, tick or command,
// yields exactly one result transaction on m_axis carrying duty and the three
// wave bits as they stand after that item.
// configuration: cfg_we with cfg_index selects volume, channel 2 weight or
// output enable; a volume write of 0..3 also forces all wave bits low.
// pipeline: two register stages, the input register, then channel update and
// mixing into the result register.
// throughput: one transaction per cycle while the result stream is not stalled;
// all three channels step together on a tick.
// reset: all channels stopped with zero period and count, wave bits low,
// volume off, channel 2 weight 1, output disabled; both stages empty.
// stall: when m_axis_tready is low the result register holds, the input
// register still takes one more transaction, then s_axis_tready drops until
// the result is taken.
module three_channel_square_tone_mixer_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [1:0] channel, [8:2] note, [9] note_on, rest zero
	input  logic        s_axis_tuser,   // [0] kind
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [5:0] duty, [8:6] wave_bits, rest zero
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);
	import tcsm_pkg::*;

	// input register stage
	logic       valid_s1;
	logic       kind_s1;
	logic [1:0] channel_s1;
	logic [6:0] note_s1;
	logic       note_on_s1;

	// result register
	logic       out_valid_q;
	logic [5:0] duty_q;
	logic [2:0] wave_bits_q;

	// configuration registers
	logic [2:0] volume_q;
	logic [1:0] weight_q;
	logic       enable_q;

	logic       advance;
	logic       take;
	logic       is_tick;
	logic       is_note;
	logic       note_ok;
	logic       any_stop;
	logic       cfg_clear;
	logic [PERIOD_W-1:0] period_lookup;
	chan_ctrl_t ctrl [NUM_CH];
	logic [NUM_CH-1:0] wave_next;
	logic [NUM_CH-1:0] wave_cur;
	logic [5:0] duty_next;

	// result register can load when empty or being drained
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload of the input stage, loaded on every accepted transaction
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1    <= s_axis_tuser;
			channel_s1 <= s_axis_tdata[1:0];
			note_s1    <= s_axis_tdata[8:2];
			note_on_s1 <= s_axis_tdata[9];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= VOLUME_RST;
			weight_q <= WEIGHT_RST;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GLOBAL_VOLUME:   volume_q <= cfg_data;
				CFG_CHANNEL2_WEIGHT: weight_q <= cfg_data[1:0];
				CFG_OUTPUT_ENABLE:   enable_q <= cfg_data[0];
				default:             ;
			endcase
		end
	end

	// an audible volume write silences every channel
	assign cfg_clear = cfg_we && (cfg_index == CFG_GLOBAL_VOLUME) && (cfg_data < VOLUME_OFF);

	// command decode for the item in the input stage
	assign is_tick       = take && (kind_s1 == KIND_TICK);
	assign is_note       = take && (kind_s1 == KIND_NOTE);
	assign note_ok       = ({1'b0, note_s1} < NOTE_LIMIT);
	assign period_lookup = half_period(note_s1);
	// stop for channel 3 is a no-op, so it must not clear the waves
	assign any_stop      = is_note && !note_on_s1 && (channel_s1 < 2'(NUM_CH));

	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		logic sel;
		assign sel = is_note && (channel_s1 == 2'(i));

		always_comb begin
			ctrl[i].tick   = is_tick;
			ctrl[i].start  = sel && note_on_s1 && note_ok;
			ctrl[i].stop   = sel && !note_on_s1;
			ctrl[i].clear  = any_stop || cfg_clear;
			ctrl[i].period = period_lookup;
		end

		tcsm_channel u_channel (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[i]),
			.wave_next (wave_next[i]),
			.wave_q    (wave_cur[i])
		);
	end

	// mix the wave bits as they will stand after this item
	tcsm_mixer u_mixer (
		.wave_bits (wave_next),
		.volume    (volume_q),
		.weight    (weight_q),
		.enable    (enable_q),
		.duty      (duty_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			duty_q      <= duty_next;
			wave_bits_q <= wave_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, wave_bits_q, duty_q};

	`include "three_channel_square_tone_mixer_core_assert.svh"

	// a result only appears after an item sat in the input stage
	`TCSM_ASSERT(a_result_from_s1, clk, arst_n, $rose(out_valid_q) |-> $past(valid_s1), "result without input")
	// the mixed level never exceeds full scale
	`TCSM_ASSERT(a_duty_range, clk, arst_n, out_valid_q |-> (duty_q <= 6'd32), "duty out of range")
	// a blocked input stage keeps its item
	`TCSM_ASSERT(a_s1_hold, clk, arst_n, (valid_s1 && !advance) |=> (valid_s1 && $stable(kind_s1) && $stable(channel_s1) && $stable(note_s1) && $stable(note_on_s1)), "input stage lost")
	// the registered wave bits follow the channel state when a result is loaded
	`TCSM_ASSERT(a_wave_match, clk, arst_n, $past(take) |-> (wave_bits_q == wave_cur), "wave bits mismatch")

endmodule
